// ===== hw/rtl/gcd_pkg.sv =====
// Package of the greedy change dispenser: sizes, coin tables, types.
package gcd_pkg;

  localparam int NUM_DENOMS  = 15;
  localparam int AMOUNT_BITS = 20;
  localparam int DENOM_W     = 16;
  localparam int TAKE_W      = 7;
  localparam int BIT_W       = (TAKE_W > 1) ? $clog2(TAKE_W) : 1;
  localparam int IDX_W       = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam int OUT_IDX_W   = 4;
  localparam int WORK_W      = ((AMOUNT_BITS > DENOM_W) ? AMOUNT_BITS : DENOM_W) + TAKE_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DENOMS - 1);
  localparam logic [BIT_W-1:0] TOP_BIT  = BIT_W'(TAKE_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FAIL,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_taken;
    logic wr_taken;
    logic commit;
  } stk_ctl_t;

  typedef struct packed {
    logic                   fits;
    logic [AMOUNT_BITS-1:0] rest;
    logic [TAKE_W-1:0]      take;
  } trial_t;

  function automatic logic [DENOM_W-1:0] denom_value(input logic [3:0] idx);
    logic [DENOM_W-1:0] v;
    unique case (idx)
      4'd0:    v = DENOM_W'(1);
      4'd1:    v = DENOM_W'(2);
      4'd2:    v = DENOM_W'(5);
      4'd3:    v = DENOM_W'(10);
      4'd4:    v = DENOM_W'(20);
      4'd5:    v = DENOM_W'(50);
      4'd6:    v = DENOM_W'(100);
      4'd7:    v = DENOM_W'(200);
      4'd8:    v = DENOM_W'(500);
      4'd9:    v = DENOM_W'(1000);
      4'd10:   v = DENOM_W'(2000);
      4'd11:   v = DENOM_W'(5000);
      4'd12:   v = DENOM_W'(10000);
      4'd13:   v = DENOM_W'(20000);
      4'd14:   v = DENOM_W'(50000);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [TAKE_W-1:0] stock_at_reset(input logic [3:0] idx);
    logic [TAKE_W-1:0] v;
    unique case (idx)
      4'd0:    v = TAKE_W'(89);
      4'd1:    v = TAKE_W'(13);
      4'd2:    v = TAKE_W'(28);
      4'd3:    v = TAKE_W'(7);
      4'd4:    v = TAKE_W'(14);
      4'd5:    v = TAKE_W'(30);
      4'd6:    v = TAKE_W'(48);
      4'd7:    v = TAKE_W'(12);
      4'd8:    v = TAKE_W'(27);
      4'd9:    v = TAKE_W'(11);
      4'd10:   v = TAKE_W'(23);
      4'd11:   v = TAKE_W'(0);
      4'd12:   v = TAKE_W'(4);
      4'd13:   v = TAKE_W'(16);
      4'd14:   v = TAKE_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/gcd_trial_unit.sv =====
// Shared trial unit: tests one quotient bit of the coin count for one denomination.
module gcd_trial_unit import gcd_pkg::*; (
  input  logic [AMOUNT_BITS-1:0] rest,
  input  logic [DENOM_W-1:0]     denom,
  input  logic [BIT_W-1:0]       bit_sel,
  input  logic [TAKE_W-1:0]      take,
  input  logic [TAKE_W-1:0]      held,
  output trial_t                 res
);

  logic [WORK_W-1:0] cand;
  logic [WORK_W-1:0] rest_ext;
  logic [TAKE_W-1:0] take_try;

  assign cand     = WORK_W'(denom) << bit_sel;
  assign rest_ext = WORK_W'(rest);
  assign take_try = take | (TAKE_W'(1) << bit_sel);

  // The bit is kept when both the amount and the stock allow it.
  assign res.fits = (cand <= rest_ext) && (take_try <= held);
  assign res.rest = res.fits ? AMOUNT_BITS'(rest_ext - cand) : rest;
  assign res.take = res.fits ? take_try : take;

endmodule

// ===== hw/rtl/gcd_stock.sv =====
// Coin inventory and per-request coin counts, with the commit of a payout.
module gcd_stock import gcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stk_ctl_t              ctl,
  input  logic [IDX_W-1:0]      idx,
  input  logic [TAKE_W-1:0]     wr_take,
  output logic [TAKE_W-1:0]     held_rd,
  output logic [TAKE_W-1:0]     taken_rd,
  output logic [NUM_DENOMS-1:0] nz_mask
);

  logic [TAKE_W-1:0] held_r  [NUM_DENOMS];
  logic [TAKE_W-1:0] taken_r [NUM_DENOMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        held_r[i]  <= stock_at_reset(4'(i));
        taken_r[i] <= '0;
      end
    end else begin
      if (ctl.commit) begin
        for (int i = 0; i < NUM_DENOMS; i++) begin
          held_r[i] <= held_r[i] - taken_r[i];
        end
      end
      if (ctl.clr_taken) begin
        for (int i = 0; i < NUM_DENOMS; i++) begin
          taken_r[i] <= '0;
        end
      end else if (ctl.wr_taken) begin
        taken_r[idx] <= wr_take;
      end
    end
  end

  assign held_rd  = held_r[idx];
  assign taken_rd = taken_r[idx];

  always_comb begin
    for (int i = 0; i < NUM_DENOMS; i++) begin
      nz_mask[i] = (taken_r[i] != '0);
    end
  end

endmodule

// ===== hw/rtl/greedy_change_dispenser.sv =====
// Top level of the greedy change dispenser: sequencer, result register and instances.
//
// Usage: an amount in grosz is presented on in_amount with in_valid; it is taken
// at a rising edge where in_valid is high and in_stall is low. The block then
// stalls its input until the request is fully handled. Results leave on the out_
// channel, one word per denomination paid out, in ascending denomination order,
// with out_last set on the final word. If the amount cannot be covered exactly
// from stock, a single word with out_ok low and out_last high is sent and the
// stock is left untouched. A zero amount produces no word at all.
//
// Timing: the shared trial unit settles one bit of a coin count per cycle, from
// the top bit down, for each denomination in turn from the highest down. A
// decision step follows; on success a commit step and the result walk, which
// visits each denomination in ascending order, come next, and the next amount
// is taken after the walk ends; after a failed request the next amount is
// taken once the failure word is loaded into the output register.
// Results sit in an output register, so a stalled receiver only holds back the
// result walk; a new amount is taken once the previous walk has ended.
// Reset restores the starting inventory, clears all counts and empties the
// output register; in_stall is held high while reset is asserted.
module greedy_change_dispenser import gcd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [AMOUNT_BITS-1:0] in_amount,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_ok,
  output logic [OUT_IDX_W-1:0]   out_denom_index,
  output logic [TAKE_W-1:0]      out_coins_given,
  output logic                   out_last
);

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r;
  logic [BIT_W-1:0]       bit_r;
  logic [AMOUNT_BITS-1:0] rest_r;
  logic [TAKE_W-1:0]      take_r;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [OUT_IDX_W-1:0]   out_idx_r;
  logic [TAKE_W-1:0]      out_coins_r;
  logic                   out_last_r;

  stk_ctl_t               stk_ctl;
  logic [TAKE_W-1:0]      held_rd;
  logic [TAKE_W-1:0]      taken_rd;
  logic [NUM_DENOMS-1:0]  nz_mask;
  trial_t                 trial;

  logic                   slot_free;
  logic                   emit_adv;
  logic                   emit_last;
  logic                   load_ok;
  logic                   load_fail;

  gcd_trial_unit u_trial (
    .rest    (rest_r),
    .denom   (denom_value(4'(idx_r))),
    .bit_sel (bit_r),
    .take    (take_r),
    .held    (held_rd),
    .res     (trial)
  );

  gcd_stock u_stock (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stk_ctl),
    .idx      (idx_r),
    .wr_take  (trial.take),
    .held_rd  (held_rd),
    .taken_rd (taken_rd),
    .nz_mask  (nz_mask)
  );

  // The output register can take a word when empty or when its word leaves now.
  assign slot_free = !out_valid_r || !out_stall;
  // Denominations with no coins are skipped without waiting for the receiver.
  assign emit_adv  = (taken_rd == '0) || slot_free;

  // A word is the last one when no higher denomination has coins to pay.
  always_comb begin
    emit_last = 1'b1;
    for (int j = 0; j < NUM_DENOMS; j++) begin
      if ((IDX_W'(j) > idx_r) && nz_mask[j]) begin
        emit_last = 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if ((bit_r == '0) && (idx_r == '0)) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = (rest_r != '0) ? ST_FAIL : ST_COMMIT;
      ST_FAIL:   if (slot_free) state_nxt = ST_IDLE;
      ST_COMMIT: state_nxt = ST_EMIT;
      ST_EMIT:   if (emit_adv && (idx_r == LAST_IDX)) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    stk_ctl   = '0;
    load_ok   = 1'b0;
    load_fail = 1'b0;
    unique case (state_r)
      ST_IDLE:   stk_ctl.clr_taken = in_valid;
      ST_SCAN:   stk_ctl.wr_taken  = (bit_r == '0);
      ST_DECIDE: ;
      ST_FAIL: begin
        load_fail         = slot_free;
        stk_ctl.clr_taken = 1'b1;
      end
      ST_COMMIT: stk_ctl.commit = 1'b1;
      ST_EMIT:   load_ok = (taken_rd != '0) && slot_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      bit_r   <= '0;
      rest_r  <= '0;
      take_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            idx_r  <= LAST_IDX;
            bit_r  <= TOP_BIT;
            rest_r <= in_amount;
            take_r <= '0;
          end
        end
        ST_SCAN: begin
          rest_r <= trial.rest;
          if (bit_r == '0) begin
            // The count for this denomination is final; start the next one down.
            bit_r  <= TOP_BIT;
            take_r <= '0;
            if (idx_r != '0) idx_r <= idx_r - IDX_W'(1);
          end else begin
            bit_r  <= bit_r - BIT_W'(1);
            take_r <= trial.take;
          end
        end
        ST_COMMIT: idx_r <= '0;
        ST_EMIT: begin
          if (emit_adv && (idx_r != LAST_IDX)) idx_r <= idx_r + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ok || load_fail) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      out_ok_r    <= 1'b1;
      out_idx_r   <= OUT_IDX_W'(idx_r);
      out_coins_r <= taken_rd;
      out_last_r  <= emit_last;
    end else if (load_fail) begin
      out_ok_r    <= 1'b0;
      out_idx_r   <= '0;
      out_coins_r <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign in_stall        = !rst_n || (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_denom_index = out_idx_r;
  assign out_coins_given = out_coins_r;
  assign out_last        = out_last_r;

endmodule

// ===== hw/rtl/gcd_checker.sv =====
// Port-level checks of the greedy change dispenser, bound to its top level.
module gcd_checker import gcd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_ok,
  input logic [OUT_IDX_W-1:0]   out_denom_index,
  input logic [TAKE_W-1:0]      out_coins_given,
  input logic                   out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_denom_index)
      && $stable(out_coins_given) && $stable(out_last))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off while a request is handled");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_last && (out_denom_index == '0) && (out_coins_given == '0))
    else $error("failure word malformed");

  a_ok_coins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> (out_coins_given != '0))
    else $error("payout word with no coins");

endmodule

bind greedy_change_dispenser gcd_checker u_gcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_ok          (out_ok),
  .out_denom_index (out_denom_index),
  .out_coins_given (out_coins_given),
  .out_last        (out_last)
);
